### hdl/gom_pkg.sv
// shared types and constants for the gabor orientation modulator
package gom_pkg;

    // item kinds carried on s_tuser
    typedef logic [1:0] op_t;
    localparam op_t OP_LOAD = 2'd0;
    localparam op_t OP_FWD  = 2'd1;
    localparam op_t OP_BWD  = 2'd2;

    // fixed field widths
    localparam int VALUE_W  = 16;
    localparam int TAP_W    = 6;
    localparam int ORIENT_W = 3;
    localparam int RESULT_W = 32;
    localparam int COUNT_W  = 4;

    // gradient accumulator width, wraps in two's complement
    localparam int ACC_W = 36;

    // most results one forward item may produce
    localparam int RESULT_CAP = 8;

    // beat packing
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

endpackage

### hdl/gabor_orientation_modulator.sv
// gabor orientation modulator top level: bank memory, shared multiplier, sequencer
//
// Fixed-point Gabor modulation of convolution weights in Q2.14. Each input beat carries a
// kind on s_tuser. A load beat writes one bank entry at (orient, tap). A forward beat takes
// one weight at a tap and returns one beat per orientation in use (num_orient, clamped to
// 1..MAX_ORIENT and at most 8), each the weight times the bank entry shifted right by
// FRAC_BITS with floor rounding, m_tlast on the final one. A backward beat multiplies one
// gradient by the entry at (orient, tap) and adds it to a 36-bit wrapping accumulator;
// orient 0 restarts the sum, and the last orientation returns the shifted sum as one beat
// and clears it. Out-of-range items and kind 3 return nothing. All products go through
// one 16x16 multiplier; the bank has one write port and a registered read port. Each
// orientation passes a read and a multiply state, then an output state (forward) or an
// accumulate state (backward, with an output state after the last orientation). An output
// state waits while m_tready holds back a result. s_tready is high only while the sequencer
// is idle. Bank entries are meaningless until loaded. The user must write num_orient (reset
// value 4) through cfg_wr_en / cfg_wr_data only while the block is idle; not enforced.
module gabor_orientation_modulator #(
    parameter int MAX_ORIENT = 8,
    parameter int MAX_TAPS   = 64,
    parameter int FRAC_BITS  = 14
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input beats
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gom_pkg::S_TDATA_W-1:0]  s_tdata,  // value[15:0], tap[21:16], orient[24:22]
    input  logic [1:0]                     s_tuser,  // op[1:0]
    // result beats
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gom_pkg::M_TDATA_W-1:0]  m_tdata,  // result_value[31:0], result_orient[34:32]
    output logic                           m_tlast,
    // orientation count register
    input  logic                           cfg_wr_en,
    input  logic [gom_pkg::COUNT_W-1:0]    cfg_wr_data
);
    import gom_pkg::*;

    // bank address split into an orientation row and a tap column
    localparam int ORI_AW = (MAX_ORIENT > 1) ? $clog2(MAX_ORIENT) : 1;
    localparam int TAP_AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int ADDR_W = ORI_AW + TAP_AW;
    localparam int DEPTH  = MAX_ORIENT << TAP_AW;
    localparam int N_CAP  = (MAX_ORIENT < RESULT_CAP) ? MAX_ORIENT : RESULT_CAP;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_EMIT,
        ST_ACC,
        ST_BEMIT
    } state_t;

    // unpacked input fields
    logic signed [VALUE_W-1:0]  in_value;
    logic        [TAP_W-1:0]    in_tap;
    logic        [ORIENT_W-1:0] in_orient;
    op_t                        in_op;

    assign in_value  = s_tdata[VALUE_W-1:0];
    assign in_tap    = s_tdata[VALUE_W+TAP_W-1:VALUE_W];
    assign in_orient = s_tdata[VALUE_W+TAP_W+ORIENT_W-1:VALUE_W+TAP_W];
    assign in_op     = s_tuser;

    // registers
    state_t                     state_reg, state_next;
    logic [COUNT_W-1:0]         num_orient_reg, num_orient_next;
    op_t                        op_reg, op_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;
    logic [TAP_W-1:0]           tap_reg, tap_next;
    logic [ORIENT_W-1:0]        k_reg, k_next;
    logic signed [RESULT_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [RESULT_W-1:0]        m_value_reg, m_value_next;
    logic [ORIENT_W-1:0]        m_orient_reg, m_orient_next;
    logic                       m_tlast_reg, m_tlast_next;

    // bank memory
    logic signed [VALUE_W-1:0]  bank_mem [DEPTH];
    logic signed [VALUE_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       bank_we;

    // zero-padded fields for address building
    logic [TAP_AW+TAP_W-1:0]       in_tap_wide, tap_wide;
    logic [ORI_AW+ORIENT_W-1:0]    in_ori_wide, k_wide;

    // effective orientation count, 1..N_CAP
    logic [COUNT_W-1:0] n_eff;

    logic in_fire;
    logic in_tap_ok;
    logic out_free;
    logic k_is_last;
    logic signed [ACC_W-1:0] acc_sum;

    always_comb begin
        if (num_orient_reg == '0) begin
            n_eff = COUNT_W'(1);
        end else if (32'(num_orient_reg) > N_CAP) begin
            n_eff = COUNT_W'(N_CAP);
        end else begin
            n_eff = num_orient_reg;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign in_tap_ok = (32'(in_tap) < MAX_TAPS);
    // output register can take a new result
    assign out_free  = !m_tvalid_reg || m_tready;
    assign k_is_last = ((COUNT_W'(k_reg) + COUNT_W'(1)) == n_eff);

    assign in_tap_wide = {{TAP_AW{1'b0}}, in_tap};
    assign tap_wide    = {{TAP_AW{1'b0}}, tap_reg};
    assign in_ori_wide = {{ORI_AW{1'b0}}, in_orient};
    assign k_wide      = {{ORI_AW{1'b0}}, k_reg};

    assign bank_we = in_fire && (in_op == OP_LOAD) && in_tap_ok
                     && (32'(in_orient) < MAX_ORIENT);
    assign wr_addr = {in_ori_wide[ORI_AW-1:0], in_tap_wide[TAP_AW-1:0]};
    assign rd_addr = {k_wide[ORI_AW-1:0], tap_wide[TAP_AW-1:0]};

    // orientation 0 restarts the running sum
    assign acc_sum = ((k_reg == '0) ? '0 : acc_reg) + ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (bank_we) begin
            bank_mem[wr_addr] <= in_value;
        end
        rd_data_reg <= bank_mem[rd_addr];
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        num_orient_next = num_orient_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        tap_next        = tap_reg;
        k_next          = k_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_value_next    = m_value_reg;
        m_orient_next   = m_orient_reg;
        m_tlast_next    = m_tlast_reg;

        // result beat leaves
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            num_orient_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    op_next    = in_op;
                    value_next = in_value;
                    tap_next   = in_tap;
                    if (in_op == OP_FWD && in_tap_ok) begin
                        k_next     = '0;
                        state_next = ST_READ;
                    end else if (in_op == OP_BWD && in_tap_ok
                                 && (COUNT_W'(in_orient) < n_eff)) begin
                        k_next     = in_orient;
                        state_next = ST_READ;
                    end
                end
            end
            // bank word for (k, tap) is registered at this edge
            ST_READ: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = RESULT_W'(value_reg) * RESULT_W'(rd_data_reg);
                state_next = (op_reg == OP_FWD) ? ST_EMIT : ST_ACC;
            end
            // forward result, floor shift of the product
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = RESULT_W'(prod_reg >>> FRAC_BITS);
                    m_orient_next = k_reg;
                    m_tlast_next  = k_is_last;
                    if (k_is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + ORIENT_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_ACC: begin
                acc_next   = acc_sum;
                state_next = k_is_last ? ST_BEMIT : ST_IDLE;
            end
            // backward result, then clear the sum
            ST_BEMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = RESULT_W'(acc_reg >>> FRAC_BITS);
                    m_orient_next = k_reg;
                    m_tlast_next  = 1'b1;
                    acc_next      = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            num_orient_reg <= COUNT_W'(4);
            acc_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            num_orient_reg <= num_orient_next;
            acc_reg        <= acc_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        op_reg       <= op_next;
        value_reg    <= value_next;
        tap_reg      <= tap_next;
        k_reg        <= k_next;
        prod_reg     <= prod_next;
        m_value_reg  <= m_value_next;
        m_orient_reg <= m_orient_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-RESULT_W-ORIENT_W){1'b0}}, m_orient_reg, m_value_reg};
    assign m_tlast  = m_tlast_reg;

endmodule
